FILE: sv/hbw_pkg.sv
package hbw_pkg;

    localparam int CHANNELS_DEF           = 4;
    localparam int COUNTER_BITS_DEF       = 17;
    localparam int TIMER_REGS             = 4;
    localparam int DEFAULT_STEP_MS        = 100;

    localparam int ENABLE_W  = 4;
    localparam int STEP_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int COUNT_W   = 3;
    localparam int MASK_W    = 4;
    localparam int CHAN_W    = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [ENABLE_W-1:0]  ENABLE_RST  = 4'hF;
    localparam logic [STEP_W-1:0]    STEP_RST    = STEP_W'(DEFAULT_STEP_MS);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [COUNT_W-1:0]   COUNT_SAT   = 3'd7;

    // register index, byte address is 4 * index
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_TMO0   = 3'd2;
    localparam logic [2:0] REG_TMO1   = 3'd3;
    localparam logic [2:0] REG_TMO2   = 3'd4;
    localparam logic [2:0] REG_TMO3   = 3'd5;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

FILE: sv/multi_channel_heartbeat_watchdog.sv
// Heartbeat watchdog over CHANNELS channels. Each request is a pet (clears one
// channel's elapsed counter and fault flag) or a tick (checks every channel)
// and yields exactly one result. A pet goes straight to the done state, which
// loads the output register once it is free. A tick walks the channels one per
// cycle through a single compare/add unit fed from the elapsed-counter RAM,
// whose registered read sits in a pipeline register ahead of that unit. The
// input stalls from acceptance until the result is in the output register,
// which then waits independently of the next request.
// Elapsed counters reset to zero through per-channel valid bits, so no clearing
// pass is needed. Registers sit on an APB port at byte addresses 0x00..0x14.
module multi_channel_heartbeat_watchdog #(
    parameter int CHANNELS     = hbw_pkg::CHANNELS_DEF,
    parameter int COUNTER_BITS = hbw_pkg::COUNTER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [hbw_pkg::CHAN_W-1:0]        i_channel,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hbw_pkg::COUNT_W-1:0]       o_fault_count,
    output logic [hbw_pkg::MASK_W-1:0]        o_fault_mask,
    output logic                              o_all_clear,
    output logic                              o_count_changed,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbw_pkg::ADDR_W-1:0]        paddr,
    input  logic [hbw_pkg::DATA_W-1:0]        pwdata,
    output logic [hbw_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = IW + 2;
    localparam int MB = (CHANNELS < hbw_pkg::MASK_W) ? CHANNELS : hbw_pkg::MASK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    // configuration registers
    logic [hbw_pkg::ENABLE_W-1:0]  r_enable;
    logic [hbw_pkg::STEP_W-1:0]    r_step;
    logic [hbw_pkg::TIMEOUT_W-1:0] r_tmo [hbw_pkg::TIMER_REGS];

    // channel state
    logic [CHANNELS-1:0]           r_flt;
    logic [CHANNELS-1:0]           r_elap_vld;
    logic [hbw_pkg::COUNT_W-1:0]   r_last;
    logic [hbw_pkg::COUNT_W-1:0]   r_prior;
    logic                          r_chg;

    // sequencer
    hbw_pkg::t_state               r_state;
    hbw_pkg::t_state               n_state;
    logic                          r_iss;
    logic [IW-1:0]                 r_idx;
    logic                          r_ex_vld;
    logic [IW-1:0]                 r_ex_idx;
    logic [hbw_pkg::COUNT_W-1:0]   r_cnt;
    logic [hbw_pkg::COUNT_W-1:0]   n_cnt;

    // output register
    logic                          r_out_vld;
    logic [hbw_pkg::COUNT_W-1:0]   r_o_cnt;
    logic [hbw_pkg::MASK_W-1:0]    r_o_mask;
    logic                          r_o_clr;
    logic                          r_o_chg;

    logic                          cfg_wr;
    logic                          in_acc;
    logic                          out_free;
    logic                          load_out;
    logic                          scan_last;
    logic [XW-1:0]                 pet_ext;
    logic                          pet_ok;
    logic [IW-1:0]                 pet_idx;
    logic [XW-1:0]                 ex_ext;
    logic [1:0]                    tmo_sel;
    logic                          chk_on;
    logic                          flt_now;
    logic                          ram_we;
    logic                          ram_re;
    logic [COUNTER_BITS-1:0]       ram_rdata;
    logic [COUNTER_BITS-1:0]       elap_cur;
    logic                          expired;
    logic [COUNTER_BITS-1:0]       elap_next;
    logic [hbw_pkg::MASK_W-1:0]    cur_mask;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            hbw_pkg::REG_ENABLE: prdata = hbw_pkg::DATA_W'(r_enable);
            hbw_pkg::REG_STEP:   prdata = hbw_pkg::DATA_W'(r_step);
            hbw_pkg::REG_TMO0:   prdata = hbw_pkg::DATA_W'(r_tmo[0]);
            hbw_pkg::REG_TMO1:   prdata = hbw_pkg::DATA_W'(r_tmo[1]);
            hbw_pkg::REG_TMO2:   prdata = hbw_pkg::DATA_W'(r_tmo[2]);
            hbw_pkg::REG_TMO3:   prdata = hbw_pkg::DATA_W'(r_tmo[3]);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= hbw_pkg::ENABLE_RST;
            r_step   <= hbw_pkg::STEP_RST;
            for (int i = 0; i < hbw_pkg::TIMER_REGS; i++) begin
                r_tmo[i] <= hbw_pkg::TIMEOUT_RST;
            end
        end else if (cfg_wr) begin
            case (paddr[4:2])
                hbw_pkg::REG_ENABLE: r_enable <= pwdata[hbw_pkg::ENABLE_W-1:0];
                hbw_pkg::REG_STEP:   r_step   <= pwdata[hbw_pkg::STEP_W-1:0];
                hbw_pkg::REG_TMO0:   r_tmo[0] <= pwdata[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO1:   r_tmo[1] <= pwdata[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO2:   r_tmo[2] <= pwdata[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO3:   r_tmo[3] <= pwdata[hbw_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and scan decode
    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        out_free  = !r_out_vld || !i_out_stall;
        scan_last = r_ex_vld && (r_ex_idx == LAST_IDX);
        pet_ext   = XW'(i_channel);
        pet_ok    = pet_ext < XW'(CHANNELS);
        pet_idx   = pet_ext[IW-1:0];
        ex_ext    = XW'(r_ex_idx);
        tmo_sel   = ex_ext[1:0];
        // only the first four channels have registers and can be watched
        chk_on    = (ex_ext < XW'(hbw_pkg::TIMER_REGS)) && r_enable[tmo_sel]
                    && !r_flt[r_ex_idx];
        elap_cur  = r_elap_vld[r_ex_idx] ? ram_rdata : '0;
        flt_now   = r_flt[r_ex_idx] || (chk_on && expired);
        n_cnt     = (flt_now && (r_cnt != hbw_pkg::COUNT_SAT)) ?
                    r_cnt + hbw_pkg::COUNT_W'(1) : r_cnt;
        ram_re    = (r_state == hbw_pkg::ST_SCAN) && r_iss;
        ram_we    = (r_state == hbw_pkg::ST_SCAN) && r_ex_vld && chk_on && !expired;
        cur_mask  = hbw_pkg::MASK_W'(r_flt[MB-1:0]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == hbw_pkg::OP_TICK) ? hbw_pkg::ST_SCAN :
                                                               hbw_pkg::ST_DONE;
                end
            end
            hbw_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = hbw_pkg::ST_DONE;
                end
            end
            hbw_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = hbw_pkg::ST_IDLE;
                end
            end
            default: n_state = hbw_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        case (r_state)
            hbw_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                load_out   = 1'b0;
            end
            hbw_pkg::ST_DONE: begin
                o_in_stall = 1'b1;
                load_out   = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
                load_out   = 1'b0;
            end
        endcase
    end

    hbw_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (CHANNELS)
    ) u_elap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ex_idx),
        .i_wdata (elap_next),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    hbw_unit #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_unit (
        .i_elapsed (elap_cur),
        .i_timeout (r_tmo[tmo_sel]),
        .i_step    (r_step),
        .o_expired (expired),
        .o_next    (elap_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hbw_pkg::ST_IDLE;
            r_iss      <= 1'b0;
            r_idx      <= '0;
            r_ex_vld   <= 1'b0;
            r_cnt      <= '0;
            r_flt      <= '0;
            r_elap_vld <= '0;
            r_last     <= '0;
            r_prior    <= '0;
            r_chg      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                if (i_opcode == hbw_pkg::OP_PET) begin
                    r_chg <= 1'b0;
                    if (pet_ok) begin
                        r_flt[pet_idx]      <= 1'b0;
                        r_elap_vld[pet_idx] <= 1'b0;
                    end
                end else begin
                    r_idx    <= '0;
                    r_iss    <= 1'b1;
                    r_ex_vld <= 1'b0;
                    r_cnt    <= '0;
                end
            end

            if (r_state == hbw_pkg::ST_SCAN) begin
                // read of channel r_idx overlaps update of channel r_ex_idx
                r_ex_vld <= r_iss;
                r_ex_idx <= r_idx;
                if (r_iss) begin
                    if (r_idx == LAST_IDX) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                if (r_ex_vld) begin
                    r_cnt <= n_cnt;
                    if (chk_on && expired) begin
                        r_flt[r_ex_idx] <= 1'b1;
                    end
                    if (ram_we) begin
                        r_elap_vld[r_ex_idx] <= 1'b1;
                    end
                    if (scan_last) begin
                        r_last  <= n_cnt;
                        r_prior <= n_cnt;
                        r_chg   <= (n_cnt != r_prior);
                    end
                end
            end

            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_cnt  <= r_last;
            r_o_mask <= cur_mask;
            r_o_clr  <= (r_last == '0);
            r_o_chg  <= r_chg;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_fault_count   = r_o_cnt;
    assign o_fault_mask    = r_o_mask;
    assign o_all_clear     = r_o_clr;
    assign o_count_changed = r_o_chg;

endmodule

FILE: sv/hbw_ram.sv
module hbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hbw_unit.sv
// Shared check/advance unit: one channel per use.
module hbw_unit #(
    parameter int COUNTER_BITS = hbw_pkg::COUNTER_BITS_DEF
) (
    input  logic [COUNTER_BITS-1:0]         i_elapsed,
    input  logic [hbw_pkg::TIMEOUT_W-1:0]   i_timeout,
    input  logic [hbw_pkg::STEP_W-1:0]      i_step,
    output logic                            o_expired,
    output logic [COUNTER_BITS-1:0]         o_next
);

    localparam int W = ((COUNTER_BITS > hbw_pkg::TIMEOUT_W) ?
                        COUNTER_BITS : hbw_pkg::TIMEOUT_W) + 1;
    localparam logic [W-1:0] CNT_MAX = W'({COUNTER_BITS{1'b1}});

    logic [W-1:0] sum;

    always_comb begin
        o_expired = W'(i_elapsed) > W'(i_timeout);
        sum       = W'(i_elapsed) + W'(i_step);
        o_next    = (sum > CNT_MAX) ? {COUNTER_BITS{1'b1}} : sum[COUNTER_BITS-1:0];
    end

endmodule

FILE: sv/hbw_checker.sv
module hbw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [hbw_pkg::COUNT_W-1:0]   o_fault_count,
    input logic [hbw_pkg::MASK_W-1:0]    o_fault_mask,
    input logic                          o_all_clear,
    input logic                          o_count_changed
);

    // an accepted request holds off the next one: the input stalls after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted back to back");

    // at most the four registered channels can ever fault
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_fault_count <= 3'd4) &&
                         (o_all_clear == (o_fault_count == 3'd0))))
        else $error("fault count inconsistent");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_fault_count) && $stable(o_fault_mask) &&
             $stable(o_all_clear) && $stable(o_count_changed)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multi_channel_heartbeat_watchdog hbw_checker u_hbw_checker (.*);

FILE: dv/multi_channel_heartbeat_watchdog_tb.sv
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_tb;

    typedef struct packed {
        logic [hbw_pkg::COUNT_W-1:0] count;
        logic [hbw_pkg::MASK_W-1:0]  mask;
        logic                        all_clear;
        logic                        changed;
    } t_fault_status;

    // Tracks the watchdog's counters and flags and holds the status words still owed.
    class t_status_board;
        logic [hbw_pkg::ENABLE_W-1:0]         watch_mask;
        logic [hbw_pkg::STEP_W-1:0]           step_ms;
        logic [hbw_pkg::TIMEOUT_W-1:0]        limit_ms [hbw_pkg::TIMER_REGS];
        logic [hbw_pkg::COUNTER_BITS_DEF-1:0] elapsed_ms [hbw_pkg::CHANNELS_DEF];
        logic [hbw_pkg::CHANNELS_DEF-1:0]     tripped;
        logic [hbw_pkg::COUNT_W-1:0]          tick_count;
        logic [hbw_pkg::COUNT_W-1:0]          prev_tick_count;
        t_fault_status                        pending_status [$];
        int                                   mismatches;

        function new();
            watch_mask      = hbw_pkg::ENABLE_RST;
            step_ms         = hbw_pkg::STEP_RST;
            for (int c = 0; c < hbw_pkg::TIMER_REGS; c++) limit_ms[c] = hbw_pkg::TIMEOUT_RST;
            for (int c = 0; c < hbw_pkg::CHANNELS_DEF; c++) elapsed_ms[c] = '0;
            tripped         = '0;
            tick_count      = '0;
            prev_tick_count = '0;
            mismatches      = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [hbw_pkg::DATA_W-1:0] value);
            case (idx)
                hbw_pkg::REG_ENABLE: watch_mask  = value[hbw_pkg::ENABLE_W-1:0];
                hbw_pkg::REG_STEP:   step_ms     = value[hbw_pkg::STEP_W-1:0];
                hbw_pkg::REG_TMO0:   limit_ms[0] = value[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO1:   limit_ms[1] = value[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO2:   limit_ms[2] = value[hbw_pkg::TIMEOUT_W-1:0];
                hbw_pkg::REG_TMO3:   limit_ms[3] = value[hbw_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic op, logic [hbw_pkg::CHAN_W-1:0] ch);
            t_fault_status                      s;
            int                                 n;
            logic [hbw_pkg::COUNTER_BITS_DEF:0] sum;
            s.changed = 1'b0;
            if (op == hbw_pkg::OP_PET) begin
                elapsed_ms[ch] = '0;
                tripped[ch]    = 1'b0;
            end else begin
                n = 0;
                for (int c = 0; c < hbw_pkg::CHANNELS_DEF; c++) begin
                    if (watch_mask[c] && !tripped[c]) begin
                        if (elapsed_ms[c] > limit_ms[c]) begin
                            tripped[c] = 1'b1;
                        end else begin
                            sum = {1'b0, elapsed_ms[c]} + step_ms;
                            elapsed_ms[c] = sum[hbw_pkg::COUNTER_BITS_DEF] ? '1 :
                                            sum[hbw_pkg::COUNTER_BITS_DEF-1:0];
                        end
                    end
                    if (tripped[c]) n++;
                end
                tick_count      = (n > hbw_pkg::COUNT_SAT) ? hbw_pkg::COUNT_SAT :
                                                             hbw_pkg::COUNT_W'(n);
                s.changed       = (tick_count != prev_tick_count);
                prev_tick_count = tick_count;
            end
            s.count     = tick_count;
            s.mask      = tripped[hbw_pkg::MASK_W-1:0];
            s.all_clear = (tick_count == '0);
            pending_status.push_back(s);
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_status(t_fault_status seen);
            t_fault_status want;
            if (pending_status.size() == 0) begin
                flag_mismatch($sformatf("status %h with none outstanding", seen));
                return;
            end
            want = pending_status.pop_front();
            if (seen.count !== want.count)
                flag_mismatch($sformatf("fault_count %0d, want %0d", seen.count, want.count));
            if (seen.mask !== want.mask)
                flag_mismatch($sformatf("fault_mask %b, want %b", seen.mask, want.mask));
            if (seen.all_clear !== want.all_clear)
                flag_mismatch($sformatf("all_clear %b, want %b", seen.all_clear, want.all_clear));
            if (seen.changed !== want.changed)
                flag_mismatch($sformatf("count_changed %b, want %b", seen.changed, want.changed));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_opcode;
    logic [hbw_pkg::CHAN_W-1:0]    i_channel;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [hbw_pkg::COUNT_W-1:0]   o_fault_count;
    logic [hbw_pkg::MASK_W-1:0]    o_fault_mask;
    logic                          o_all_clear;
    logic                          o_count_changed;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [hbw_pkg::ADDR_W-1:0]    paddr;
    logic [hbw_pkg::DATA_W-1:0]    pwdata;
    logic [hbw_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    t_status_board status_board = new();
    int            idle_odds = 0;     // 0: no idling on either side
    bit            long_hold = 1'b0;

    multi_channel_heartbeat_watchdog dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_channel       (i_channel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fault_count   (o_fault_count),
        .o_fault_mask    (o_fault_mask),
        .o_all_clear     (o_all_clear),
        .o_count_changed (o_count_changed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: checks accepted status words and stalls in bursts
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall)
                status_board.check_status({o_fault_count, o_fault_mask, o_all_clear,
                                           o_count_changed});
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (long_hold) begin
                long_hold = 1'b0;
                hold_left = 79;
                i_out_stall <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                hold_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic op, input logic [hbw_pkg::CHAN_W-1:0] ch);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_channel  <= ch;
        do @(posedge i_clk); while (o_in_stall);
        status_board.note_request(op, ch);
    endtask

    task automatic sender_pause();
        int n;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            n = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (status_board.pending_status.size() != 0) @(posedge i_clk);
    endtask

    // psel stays high across back-to-back writes; caller releases the bus
    task automatic write_register(input logic [2:0] idx,
                                  input logic [hbw_pkg::DATA_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        status_board.set_register(idx, value);
    endtask

    task automatic apply_settings(
        input logic [hbw_pkg::ENABLE_W-1:0]                           en,
        input logic [hbw_pkg::STEP_W-1:0]                             st,
        input logic [hbw_pkg::TIMER_REGS-1:0][hbw_pkg::TIMEOUT_W-1:0] tmos);
        write_register(hbw_pkg::REG_ENABLE, hbw_pkg::DATA_W'(en));
        write_register(hbw_pkg::REG_STEP, hbw_pkg::DATA_W'(st));
        for (int c = 0; c < hbw_pkg::TIMER_REGS; c++)
            write_register(3'(hbw_pkg::REG_TMO0 + c), hbw_pkg::DATA_W'(tmos[c]));
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_phase(input int k);
        logic [hbw_pkg::ENABLE_W-1:0]                           en;
        logic [hbw_pkg::STEP_W-1:0]                             st;
        logic [hbw_pkg::TIMER_REGS-1:0][hbw_pkg::TIMEOUT_W-1:0] tmos;
        int                                                     pet_pct;
        logic                                                   op;
        st = (k == 0) ? hbw_pkg::STEP_W'(1000) : (k == 1) ? hbw_pkg::STEP_W'(1) :
             hbw_pkg::STEP_W'($urandom_range(1, 1000));
        en = (k < 2) ? hbw_pkg::ENABLE_RST : hbw_pkg::ENABLE_W'($urandom_range(0, 15));
        for (int c = 0; c < hbw_pkg::TIMER_REGS; c++) begin
            if (k == 0)
                tmos[c] = c[0] ? 16'hFFFF : 16'h0000;
            else
                tmos[c] = hbw_pkg::TIMEOUT_W'(st * $urandom_range(0, 14) +
                                              $urandom_range(0, st));
        end
        wait_drained();
        apply_settings(en, st, tmos);
        idle_odds = (k == 4 || k == 7) ? 0 : 4;
        pet_pct   = $urandom_range(10, 40);
        for (int j = 0; j < 166; j++) begin
            if (k == 2 && j == 80) long_hold = 1'b1;
            if (k == 3 && j == 80) wait_drained();
            op = ($urandom_range(0, 99) < pet_pct) ? hbw_pkg::OP_PET : hbw_pkg::OP_TICK;
            send_request(op, hbw_pkg::CHAN_W'($urandom_range(0, 3)));
            sender_pause();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode   <= hbw_pkg::OP_TICK;
        i_channel  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all four trip together on the twelfth tick
        // (the eleventh sees the counter equal to the timeout, not above it)
        for (int j = 0; j < 12; j++)
            send_request(hbw_pkg::OP_TICK, hbw_pkg::CHAN_W'($urandom_range(0, 3)));
        for (int c = 0; c < hbw_pkg::CHANNELS_DEF; c++)
            send_request(hbw_pkg::OP_PET, hbw_pkg::CHAN_W'(c));
        send_request(hbw_pkg::OP_TICK, '0);

        // counters already moved, so zero timeouts trip on the first tick;
        // disabled channels hold still
        wait_drained();
        apply_settings(4'b0101, hbw_pkg::STEP_W'(1000), {16'd1, 16'd0, 16'hFFFF, 16'd0});
        send_request(hbw_pkg::OP_TICK, 2'd3);
        send_request(hbw_pkg::OP_TICK, 2'd0);
        wait_drained();
        apply_settings(4'b0000, hbw_pkg::STEP_W'(1000), {16'd1, 16'd0, 16'hFFFF, 16'd0});
        send_request(hbw_pkg::OP_TICK, 2'd1);     // held flags still counted
        send_request(hbw_pkg::OP_PET, 2'd0);      // pet on a disabled, tripped channel
        send_request(hbw_pkg::OP_TICK, 2'd2);

        for (int k = 0; k < 8; k++) random_phase(k);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (status_board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
